@@ rtl/dnlp_pkg.sv @@
package dnlp_pkg;

   // Field widths
   localparam int CHAR_W = 8;
   localparam int DIGIT_W = 4;
   localparam int SIG_W = 63;
   localparam int EXP_W = 16;
   localparam int EACC_W = 15;
   localparam int DCNT_W = 5;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_E = 8'h45;
   localparam logic [CHAR_W-1:0] CH_LOWER_E = 8'h65;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

   // Saturation limits
   localparam logic signed [EXP_W-1:0] SCALE_MAX = 16'sd32767;
   localparam logic signed [EXP_W-1:0] SCALE_MIN = -16'sd32767;
   localparam logic [EACC_W-1:0] EACC_MAX = 15'h7FFF;
   localparam logic [DCNT_W-1:0] DCNT_MAX = 5'd31;

   // Decoupling queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;

   typedef enum logic [2:0] {
      CL_SPACE = 3'd0,
      CL_SIGN  = 3'd1,
      CL_DIGIT = 3'd2,
      CL_DOT   = 3'd3,
      CL_EXP   = 3'd4,
      CL_HEX_X = 3'd5,
      CL_OTHER = 3'd6
   } char_class_type;

   // One classified character word
   typedef struct packed {
      char_class_type         cls;
      logic [DIGIT_W-1:0]     digit;
      logic                   minus;
      logic                   last;
   } lex_word_type;

   typedef enum logic [1:0] {
      RS_INTEGER = 2'd0,
      RS_FLOAT   = 2'd1,
      RS_BAD     = 2'd2,
      RS_HEX     = 2'd3
   } result_status_type;

   typedef enum logic [10:0] {
      LX_INIT      = 11'h001,
      LX_SIGN      = 11'h002,
      LX_LEAD_DOT  = 11'h004,
      LX_INT       = 11'h008,
      LX_POINT     = 11'h010,
      LX_FRAC      = 11'h020,
      LX_EXP       = 11'h040,
      LX_EXP_SIGN  = 11'h080,
      LX_EXP_DIG   = 11'h100,
      LX_TRAIL     = 11'h200,
      LX_ZERO      = 11'h400
   } lex_state_type;

endpackage

@@ rtl/dnlp_front.sv @@
module dnlp_front (
   input  logic [dnlp_pkg::CHAR_W-1:0] char_code,
   input  logic                        last_char,
   output dnlp_pkg::lex_word_type      word
);
   import dnlp_pkg::*;

   // Character classification
   always_comb begin
      word.cls = CL_OTHER;
      word.digit = char_code[DIGIT_W-1:0];
      word.minus = (char_code == CH_MINUS);
      word.last = last_char;
      if ((char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR))) begin
         word.cls = CL_SPACE;
      end else if ((char_code == CH_PLUS) || (char_code == CH_MINUS)) begin
         word.cls = CL_SIGN;
      end else if ((char_code >= CH_ZERO) && (char_code <= CH_NINE)) begin
         word.cls = CL_DIGIT;
      end else if (char_code == CH_DOT) begin
         word.cls = CL_DOT;
      end else if ((char_code == CH_LOWER_E) || (char_code == CH_UPPER_E)) begin
         word.cls = CL_EXP;
      end else if ((char_code == CH_LOWER_X) || (char_code == CH_UPPER_X)) begin
         word.cls = CL_HEX_X;
      end
   end

endmodule

@@ rtl/dnlp_queue.sv @@
module dnlp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dnlp_pkg::lex_word_type push_word,
   output logic                   full,
   input  logic                   pop,
   output dnlp_pkg::lex_word_type pop_word,
   output logic                   not_empty
);
   import dnlp_pkg::*;

   lex_word_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_word = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Word storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

@@ rtl/dnlp_back.sv @@
module dnlp_back #(
   parameter int MAX_DIGITS = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  dnlp_pkg::lex_word_type           in_word,
   output logic                             in_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_negative,
   output logic [dnlp_pkg::SIG_W-1:0]       rsp_significand,
   output logic signed [dnlp_pkg::EXP_W-1:0] rsp_dec_exponent
);
   import dnlp_pkg::*;

   localparam logic [DCNT_W-1:0] DCNT_LIMIT = DCNT_W'(MAX_DIGITS);

   // Lexer state
   lex_state_type            lex_ff, lex_in;
   logic [SIG_W-1:0]         acc_ff, acc_in;
   logic [DCNT_W-1:0]        dcnt_ff, dcnt_in;
   logic signed [EXP_W-1:0]  scale_ff, scale_in;
   logic [EACC_W-1:0]        eacc_ff, eacc_in;
   logic                     minus_ff, minus_in;
   logic                     eminus_ff, eminus_in;
   logic                     float_ff, float_in;
   logic                     err_ff, err_in;
   logic                     hex_ff, hex_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               status_ff, status_in;
   logic                     neg_ff, neg_in;
   logic [SIG_W-1:0]         sig_ff, sig_in;
   logic signed [EXP_W-1:0]  dexp_ff, dexp_in;

   // Datapath intermediates
   logic [SIG_W+3:0]         acc_wide;
   logic                     acc_fits;
   logic [EACC_W+3:0]        eacc_wide;
   logic signed [EXP_W:0]    exp_sum;
   lex_state_type            ns;
   logic                     bad;
   logic                     accepting;
   logic                     work;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_negative = neg_ff;
   assign rsp_significand = sig_ff;
   assign rsp_dec_exponent = dexp_ff;

   // Take a word unless it ends a literal while the result slot is blocked
   assign work = in_valid && (!in_word.last || !rsp_valid_ff || !rsp_stall);
   assign in_pop = work;

   // Multiply-by-ten datapaths
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + (SIG_W+4)'(in_word.digit);
   assign acc_fits = (acc_wide[SIG_W+3:SIG_W] == 4'b0);
   assign eacc_wide = ({4'b0, eacc_ff} << 3) + ({4'b0, eacc_ff} << 1)
                    + (EACC_W+4)'(in_word.digit);

   // Transition table
   always_comb begin
      ns = lex_ff;
      bad = 1'b0;
      case (in_word.cls)
         CL_SPACE: begin
            case (lex_ff)
               LX_INIT, LX_TRAIL: ns = lex_ff;
               LX_INT, LX_POINT, LX_FRAC, LX_EXP_DIG, LX_ZERO: ns = LX_TRAIL;
               default: bad = 1'b1;
            endcase
         end
         CL_SIGN: begin
            case (lex_ff)
               LX_INIT: ns = LX_SIGN;
               LX_EXP: ns = LX_EXP_SIGN;
               default: bad = 1'b1;
            endcase
         end
         CL_DIGIT: begin
            case (lex_ff)
               LX_INIT, LX_SIGN: ns = (in_word.digit == '0) ? LX_ZERO : LX_INT;
               LX_LEAD_DOT, LX_POINT, LX_FRAC: ns = LX_FRAC;
               LX_INT, LX_ZERO: ns = LX_INT;
               LX_EXP, LX_EXP_SIGN, LX_EXP_DIG: ns = LX_EXP_DIG;
               default: bad = 1'b1;
            endcase
         end
         CL_DOT: begin
            case (lex_ff)
               LX_INIT, LX_SIGN: ns = LX_LEAD_DOT;
               LX_INT, LX_ZERO: ns = LX_POINT;
               default: bad = 1'b1;
            endcase
         end
         CL_EXP: begin
            case (lex_ff)
               LX_INT, LX_POINT, LX_FRAC, LX_ZERO: ns = LX_EXP;
               default: bad = 1'b1;
            endcase
         end
         default: bad = 1'b1;
      endcase
   end

   // State update for one word
   always_comb begin
      lex_in = lex_ff;
      acc_in = acc_ff;
      dcnt_in = dcnt_ff;
      scale_in = scale_ff;
      eacc_in = eacc_ff;
      minus_in = minus_ff;
      eminus_in = eminus_ff;
      float_in = float_ff;
      err_in = err_ff;
      hex_in = hex_ff;
      if (!err_ff && !hex_ff) begin
         if ((in_word.cls == CL_HEX_X) && (lex_ff == LX_ZERO)) begin
            hex_in = 1'b1;
         end else if (bad) begin
            err_in = 1'b1;
         end else begin
            lex_in = ns;
            case (ns)
               LX_SIGN: begin
                  if (in_word.minus) minus_in = 1'b1;
               end
               LX_LEAD_DOT, LX_POINT, LX_EXP: float_in = 1'b1;
               LX_INT: begin
                  if ((dcnt_ff < DCNT_LIMIT) || ((dcnt_ff == DCNT_LIMIT) && acc_fits)) begin
                     acc_in = acc_wide[SIG_W-1:0];
                  end else begin
                     float_in = 1'b1;
                     if (scale_ff < SCALE_MAX) scale_in = scale_ff + 16'sd1;
                  end
                  if (dcnt_ff < DCNT_MAX) dcnt_in = dcnt_ff + 1'b1;
               end
               LX_FRAC: begin
                  if (dcnt_ff < DCNT_LIMIT) begin
                     acc_in = acc_wide[SIG_W-1:0];
                     if (dcnt_ff < DCNT_MAX) dcnt_in = dcnt_ff + 1'b1;
                     if (scale_ff > SCALE_MIN) scale_in = scale_ff - 16'sd1;
                  end
               end
               LX_EXP_SIGN: begin
                  if (in_word.minus) eminus_in = 1'b1;
               end
               LX_EXP_DIG: begin
                  eacc_in = (eacc_wide > (EACC_W+4)'(EACC_MAX)) ? EACC_MAX
                          : eacc_wide[EACC_W-1:0];
               end
               default: ;
            endcase
         end
      end
   end

   // Result formation on the last character
   assign accepting = (lex_in == LX_INT) || (lex_in == LX_POINT) || (lex_in == LX_FRAC)
                   || (lex_in == LX_EXP_DIG) || (lex_in == LX_TRAIL) || (lex_in == LX_ZERO);
   assign exp_sum = (EXP_W+1)'(scale_in)
                  + (eminus_in ? -(EXP_W+1)'({2'b0, eacc_in}) : (EXP_W+1)'({2'b0, eacc_in}));

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in = status_ff;
      neg_in = neg_ff;
      sig_in = sig_ff;
      dexp_in = dexp_ff;
      if (work && in_word.last) begin
         rsp_valid_in = 1'b1;
         status_in = RS_BAD;
         neg_in = 1'b0;
         sig_in = '0;
         dexp_in = '0;
         if (hex_in && !err_in) begin
            status_in = RS_HEX;
         end else if (!err_in && accepting) begin
            neg_in = minus_in;
            sig_in = acc_in;
            if (float_in) begin
               status_in = RS_FLOAT;
               if (exp_sum > (EXP_W+1)'(SCALE_MAX)) begin
                  dexp_in = SCALE_MAX;
               end else if (exp_sum < (EXP_W+1)'(SCALE_MIN)) begin
                  dexp_in = SCALE_MIN;
               end else begin
                  dexp_in = exp_sum[EXP_W-1:0];
               end
            end else begin
               status_in = RS_INTEGER;
            end
         end
      end
   end

   // Lexer registers; cleared after each literal
   always_ff @(posedge clock) begin
      if (reset || (work && in_word.last)) begin
         lex_ff <= LX_INIT;
         acc_ff <= '0;
         dcnt_ff <= '0;
         scale_ff <= '0;
         eacc_ff <= '0;
         minus_ff <= 1'b0;
         eminus_ff <= 1'b0;
         float_ff <= 1'b0;
         err_ff <= 1'b0;
         hex_ff <= 1'b0;
      end else if (work) begin
         lex_ff <= lex_in;
         acc_ff <= acc_in;
         dcnt_ff <= dcnt_in;
         scale_ff <= scale_in;
         eacc_ff <= eacc_in;
         minus_ff <= minus_in;
         eminus_ff <= eminus_in;
         float_ff <= float_in;
         err_ff <= err_in;
         hex_ff <= hex_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      neg_ff <= neg_in;
      sig_ff <= sig_in;
      dexp_ff <= dexp_in;
   end

endmodule

@@ rtl/decimal_number_literal_parser.sv @@
// Decimal number literal parser.
// Request channel: one character word per accepted item on req_char_code, with
// req_last_char set on the final character of a literal. Response channel: one
// word per literal with status (integer, float, bad parse, hex prefix), sign,
// 63-bit significand and saturating decimal exponent.
// A front stage classifies each character and writes it into a two-entry
// queue; a back stage pops one word per cycle, except while a last character
// waits on a stalled response, and runs the lexer state and multiply-by-ten
// accumulators, then loads the result register. Throughput is one character
// per cycle under that condition; the lexer update of one word per cycle in
// the back stage sets that rate. With the queue otherwise empty, the last
// character goes from its queue entry to the result register and rsp_valid.
// Reset (synchronous, active high) empties the queue, returns the lexer to
// its initial state and drops any pending response.
// While rsp_stall is high the response holds; the back stage keeps consuming
// characters of the next literal and waits only on its last character, so
// req_stall rises once the queue fills.
module decimal_number_literal_parser #(
   parameter int MAX_DIGITS = 18
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dnlp_pkg::CHAR_W-1:0]        req_char_code,
   input  logic                               req_last_char,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_negative,
   output logic [dnlp_pkg::SIG_W-1:0]         rsp_significand,
   output logic signed [dnlp_pkg::EXP_W-1:0]  rsp_dec_exponent
);
   import dnlp_pkg::*;

   lex_word_type  front_word;
   lex_word_type  queue_word;
   logic          queue_full;
   logic          queue_not_empty;
   logic          queue_pop;

   assign req_stall = queue_full;

   // Classifier
   dnlp_front u_front (
      .char_code (req_char_code),
      .last_char (req_last_char),
      .word      (front_word)
   );

   // Decoupling queue
   dnlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !queue_full),
      .push_word (front_word),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_word  (queue_word),
      .not_empty (queue_not_empty)
   );

   // Lexer and result register
   dnlp_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (queue_not_empty),
      .in_word          (queue_word),
      .in_pop           (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_negative     (rsp_negative),
      .rsp_significand  (rsp_significand),
      .rsp_dec_exponent (rsp_dec_exponent)
   );

endmodule
